// File: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types, constants and helpers for the series composition block
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int COEF_W = 32;
  localparam int DEG_W  = 4;
  localparam int ACC_W  = 64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_we;
    logic init_we;
    logic mac_issue;
    logic mula_issue;
    logic acc_clr;
    logic pn_we;
    logic sum_we;
    logic out_load;
    logic out_err;
    logic out_last;
  } tsc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic center_ok;
    logic out_free;
  } tsc_stat_t;

  // saturate a wide signed value to the coefficient range
  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'({1'b0, {(COEF_W-1){1'b1}}}));
    lo = -hi - ACC_W'(1);
    if (x > hi) begin
      return hi[COEF_W-1:0];
    end else if (x < lo) begin
      return lo[COEF_W-1:0];
    end
    return x[COEF_W-1:0];
  endfunction

endpackage

// File: rtl/tsc_ifs.sv
// ----------------------------------------------------------------------------
// tsc channel interfaces
// valid/ready channels for coefficient pairs and composed results
// ----------------------------------------------------------------------------
interface tsc_in_if import tsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] outer_coef;
  logic signed [COEF_W-1:0] inner_coef;
  logic                     last_pair;

  modport source (output valid, output outer_coef, output inner_coef, output last_pair,
                  input ready);
  modport sink   (input valid, input outer_coef, input inner_coef, input last_pair,
                  output ready);
endinterface

interface tsc_out_if import tsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coefficient;
  logic        [DEG_W-1:0]  degree;
  logic                     last_result;
  logic                     status;

  modport source (output valid, output coefficient, output degree, output last_result,
                  output status, input ready);
  modport sink   (input valid, input coefficient, input degree, input last_result,
                  input status, output ready);
endinterface

// File: rtl/tsc_datapath.sv
// ----------------------------------------------------------------------------
// tsc_datapath
// coefficient memories, shared multiplier pipeline, accumulator, output register
// ----------------------------------------------------------------------------
module tsc_datapath import tsc_pkg::*; #(
  parameter int ORDER_CAP = 15,
  parameter int FRAC_BITS = 16,
  localparam int DEPTH = ORDER_CAP + 1,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tsc_cmd_t                 cmd_i,
  output tsc_stat_t                stat_o,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic [IDX_W-1:0]         term_i,
  input  logic [IDX_W-1:0]         wr_idx_i,
  input  logic signed [COEF_W-1:0] outer_coef_i,
  input  logic signed [COEF_W-1:0] inner_coef_i,
  input  logic                     cfg_we_i,
  input  logic signed [COEF_W-1:0] cfg_data_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [COEF_W-1:0] coefficient_o,
  output logic [DEG_W-1:0]         degree_o,
  output logic                     last_result_o,
  output logic                     status_o
);

  localparam logic signed [COEF_W-1:0] One = COEF_W'(1) << FRAC_BITS;

  logic signed [COEF_W-1:0] outer_mem [DEPTH];
  logic signed [COEF_W-1:0] inner_mem [DEPTH];
  logic signed [COEF_W-1:0] power_mem [DEPTH];
  logic signed [COEF_W-1:0] sum_mem   [DEPTH];

  logic signed [COEF_W-1:0] p_rd_q, g_rd_q, a_rd_q, s_rd_q;
  logic signed [COEF_W-1:0] g0_q, a0_q, center_q, pn_q;
  logic                     v1_mac_q, v1_mula_q, v2_mac_q;
  logic signed [ACC_W-1:0]  prod_q, acc_q;
  logic signed [COEF_W-1:0] mul_a, mul_b, pn_d, sum_d;
  logic signed [ACC_W-1:0]  prod_full, prod_d;
  logic [IDX_W-1:0]         g_addr;
  logic [63:0]              row_ext;

  assign g_addr  = row_i - col_i;
  assign row_ext = 64'(row_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      outer_mem[wr_idx_i] <= outer_coef_i;
      inner_mem[wr_idx_i] <= inner_coef_i;
    end
    if (cmd_i.init_we) begin
      power_mem[row_i] <= (row_i == '0) ? One : '0;
      sum_mem[row_i]   <= (row_i == '0) ? a0_q : '0;
    end else begin
      if (cmd_i.pn_we) power_mem[row_i] <= pn_d;
      if (cmd_i.sum_we) sum_mem[row_i] <= sum_d;
    end
    p_rd_q <= power_mem[col_i];
    g_rd_q <= inner_mem[g_addr];
    a_rd_q <= outer_mem[term_i];
    s_rd_q <= sum_mem[row_i];
  end

  // constant terms kept aside for the check and the initial sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && wr_idx_i == '0) begin
      g0_q <= inner_coef_i;
      a0_q <= outer_coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
    end else if (cfg_we_i) begin
      center_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_mac_q  <= 1'b0;
      v1_mula_q <= 1'b0;
      v2_mac_q  <= 1'b0;
    end else begin
      v1_mac_q  <= cmd_i.mac_issue;
      v1_mula_q <= cmd_i.mula_issue;
      v2_mac_q  <= v1_mac_q;
    end
  end

  always_comb begin
    mul_a     = v1_mula_q ? a_rd_q : p_rd_q;
    mul_b     = v1_mula_q ? pn_q   : g_rd_q;
    prod_full = ACC_W'(mul_a) * ACC_W'(mul_b);
    prod_d    = prod_full >>> FRAC_BITS;
    pn_d      = sat32(acc_q);
    sum_d     = sat32(ACC_W'(s_rd_q) + prod_q);
  end

  always_ff @(posedge clk_i) begin
    if (v1_mac_q || v1_mula_q) prod_q <= prod_d;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_mac_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.pn_we) pn_q <= pn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.out_err) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load || cmd_i.out_err) begin
      coefficient_o <= cmd_i.out_err ? '0 : s_rd_q;
      degree_o      <= cmd_i.out_err ? '0 : row_ext[DEG_W-1:0];
      last_result_o <= cmd_i.out_err ? 1'b1 : cmd_i.out_last;
      status_o      <= cmd_i.out_err;
    end
  end

  assign stat_o.center_ok = (g0_q == center_q);
  assign stat_o.out_free  = !out_valid_o || out_ready_i;

endmodule

// File: rtl/tsc_ctrl.sv
// ----------------------------------------------------------------------------
// tsc_ctrl
// sequencer for loading, power and sum updates, and result emission
// ----------------------------------------------------------------------------
module tsc_ctrl import tsc_pkg::*; #(
  parameter int ORDER_CAP = 15,
  localparam int DEPTH = ORDER_CAP + 1,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_pair_i,
  output logic             in_ready_o,
  input  tsc_stat_t        stat_i,
  output tsc_cmd_t         cmd_o,
  output logic [IDX_W-1:0] row_o,
  output logic [IDX_W-1:0] col_o,
  output logic [IDX_W-1:0] term_o,
  output logic [IDX_W-1:0] wr_idx_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StCheck  = 4'd1;
  localparam logic [3:0] StInit   = 4'd2;
  localparam logic [3:0] StIssue  = 4'd3;
  localparam logic [3:0] StDrain  = 4'd4;
  localparam logic [3:0] StPn     = 4'd5;
  localparam logic [3:0] StMula   = 4'd6;
  localparam logic [3:0] StWait   = 4'd7;
  localparam logic [3:0] StSumw   = 4'd8;
  localparam logic [3:0] StEmitRd = 4'd9;
  localparam logic [3:0] StEmitLd = 4'd10;
  localparam logic [3:0] StErr    = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] order_q, order_d, row_q, row_d, col_q, col_d, term_q, term_d;
  logic             dly_q, dly_d, full;

  assign full       = (cnt_q == CNT_W'(DEPTH));
  assign in_ready_o = (state_q == StIdle);
  assign row_o      = row_q;
  assign col_o      = col_q;
  assign term_o     = term_q;
  assign wr_idx_o   = cnt_q[IDX_W-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    order_d = order_q;
    row_d   = row_q;
    col_d   = col_q;
    term_d  = term_q;
    dly_d   = dly_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_we = !full;
          if (!full) cnt_d = cnt_q + CNT_W'(1);
          if (last_pair_i) begin
            cnt_d   = '0;
            order_d = full ? IDX_W'(DEPTH - 1) : cnt_q[IDX_W-1:0];
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        row_d   = '0;
        state_d = stat_i.center_ok ? StInit : StErr;
      end
      StInit: begin
        cmd_o.init_we = 1'b1;
        if (row_q == order_q) begin
          col_d = '0;
          if (order_q == '0) begin
            row_d   = '0;
            state_d = StEmitRd;
          end else begin
            term_d  = IDX_W'(1);
            row_d   = order_q;
            state_d = StIssue;
          end
        end else begin
          row_d = row_q + IDX_W'(1);
        end
      end
      StIssue: begin
        cmd_o.acc_clr = (col_q == '0);
        if (col_q != row_q) begin
          cmd_o.mac_issue = 1'b1;
          col_d = col_q + IDX_W'(1);
        end else begin
          dly_d   = 1'b0;
          state_d = StDrain;
        end
      end
      StDrain: begin
        dly_d = 1'b1;
        if (dly_q) state_d = StPn;
      end
      StPn: begin
        cmd_o.pn_we = 1'b1;
        state_d     = StMula;
      end
      StMula: begin
        cmd_o.mula_issue = 1'b1;
        state_d          = StWait;
      end
      StWait: begin
        state_d = StSumw;
      end
      StSumw: begin
        cmd_o.sum_we = 1'b1;
        col_d        = '0;
        if (row_q == '0) begin
          if (term_q == order_q) begin
            state_d = StEmitRd;
          end else begin
            term_d  = term_q + IDX_W'(1);
            row_d   = order_q;
            state_d = StIssue;
          end
        end else begin
          row_d   = row_q - IDX_W'(1);
          state_d = StIssue;
        end
      end
      StEmitRd: begin
        state_d = StEmitLd;
      end
      StEmitLd: begin
        cmd_o.out_last = (row_q == order_q);
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (row_q == order_q) begin
            state_d = StIdle;
          end else begin
            row_d   = row_q + IDX_W'(1);
            state_d = StEmitRd;
          end
        end
      end
      StErr: begin
        if (stat_i.out_free) begin
          cmd_o.out_err = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      order_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      term_q  <= '0;
      dly_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      order_q <= order_d;
      row_q   <= row_d;
      col_q   <= col_d;
      term_q  <= term_d;
      dly_q   <= dly_d;
    end
  end

endmodule

// File: rtl/truncated_series_composition.sv
// a pair without the last mark is simply stored; input ready only when idle
// a closing pair of order m: results follow for degrees 0 to m in order, one at a time,
// each held back while the output register is not free
// mismatch of the inner constant term gives one error transaction
// asynchronous active-low reset clears control state and the centre register
// ----------------------------------------------------------------------------
// truncated_series_composition
// composes two loaded power series, h = sum a_k (g - g0)^k, in signed fixed point
// ----------------------------------------------------------------------------
module truncated_series_composition import tsc_pkg::*; #(
  parameter int ORDER_CAP = 15,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tsc_in_if.sink                   in_ch,
  tsc_out_if.source                out_ch,
  input  logic                     cfg_we_i,
  input  logic signed [COEF_W-1:0] cfg_data_i
);

  localparam int DEPTH = ORDER_CAP + 1;
  localparam int IDX_W = $clog2(DEPTH);

  // command and status between sequencer and datapath
  tsc_cmd_t         cmd;
  tsc_stat_t        stat;
  logic [IDX_W-1:0] row, col, term, wr_idx;

  // the controller walks every term k from 1 up, every degree i from high to low and
  // every lower degree j, so the power store is updated in place
  tsc_ctrl #(
    .ORDER_CAP (ORDER_CAP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .last_pair_i (in_ch.last_pair),
    .in_ready_o  (in_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .row_o       (row),
    .col_o       (col),
    .term_o      (term),
    .wr_idx_o    (wr_idx)
  );

  // memories, multiplier pipeline and the output register
  tsc_datapath #(
    .ORDER_CAP (ORDER_CAP),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .row_i         (row),
    .col_i         (col),
    .term_i        (term),
    .wr_idx_i      (wr_idx),
    .outer_coef_i  (in_ch.outer_coef),
    .inner_coef_i  (in_ch.inner_coef),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ch.ready),
    .out_valid_o   (out_ch.valid),
    .coefficient_o (out_ch.coefficient),
    .degree_o      (out_ch.degree),
    .last_result_o (out_ch.last_result),
    .status_o      (out_ch.status)
  );

endmodule

// File: verif/tsc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsc_checker
// watches both channels, predicts composed coefficients and compares them
// ----------------------------------------------------------------------------
module tsc_checker import tsc_pkg::*; #(
  parameter int ORDER_CAP = 15,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tsc_in_if                        in_mon,
  tsc_out_if                       out_mon,
  input  logic                     cfg_we_i,
  input  logic signed [COEF_W-1:0] cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam int DEPTH = ORDER_CAP + 1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_CENTRE_MISMATCH = 1'b1;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [DEG_W-1:0]         degree;
    logic                     last_result;
    logic                     status;
  } coef_result_t;

  coef_result_t composed_q[$];
  int           centre;
  int           outer_held[DEPTH];
  int           inner_held[DEPTH];
  int           pairs_held;
  int           fails;

  assign fail_count_o = fails;
  assign pending_o    = composed_q.size();

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  // exact product, floor shift
  function automatic longint qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  task automatic compose_series();
    int           order;
    int           pw[DEPTH];
    int           nx[DEPTH];
    int           acc_sum[DEPTH];
    longint       acc;
    coef_result_t r;
    order = pairs_held - 1;
    if (inner_held[0] != centre) begin
      r = '{coefficient: '0, degree: '0, last_result: 1'b1, status: STATUS_CENTRE_MISMATCH};
      composed_q.push_back(r);
      return;
    end
    for (int i = 0; i <= order; i++) pw[i] = 0;
    pw[0] = clamp32(longint'(1) << FRAC_BITS);
    for (int i = 0; i <= order; i++) acc_sum[i] = clamp32(qmul(outer_held[0], pw[i]));
    for (int k = 1; k <= order; k++) begin
      for (int i = 0; i <= order; i++) begin
        acc = 0;
        for (int j = 0; j <= i; j++) begin
          acc += qmul(pw[j], (i == j) ? 0 : inner_held[i-j]);
        end
        nx[i] = clamp32(acc);
      end
      for (int i = 0; i <= order; i++) begin
        pw[i] = nx[i];
        acc_sum[i] = clamp32(longint'(acc_sum[i]) + qmul(outer_held[k], pw[i]));
      end
    end
    for (int i = 0; i <= order; i++) begin
      r = '{coefficient: acc_sum[i], degree: DEG_W'(i), last_result: (i == order),
            status: STATUS_OK};
      composed_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coef_result_t e;
    if (!rst_ni) begin
      composed_q.delete();
      centre     = 0;
      pairs_held = 0;
      fails      = 0;
    end else begin
      if (cfg_we_i) centre = cfg_data_i;
      if (in_mon.valid && in_mon.ready) begin
        if (pairs_held < DEPTH) begin
          outer_held[pairs_held] = in_mon.outer_coef;
          inner_held[pairs_held] = in_mon.inner_coef;
          pairs_held++;
        end
        if (in_mon.last_pair) begin
          compose_series();
          pairs_held = 0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (composed_q.size() == 0) begin
          $error("unexpected result transaction, degree %0d", out_mon.degree);
          fails++;
        end else begin
          e = composed_q.pop_front();
          if (out_mon.coefficient !== e.coefficient) begin
            $error("coefficient: expected %0d, got %0d", e.coefficient, out_mon.coefficient);
            fails++;
          end
          if (out_mon.degree !== e.degree) begin
            $error("degree: expected %0d, got %0d", e.degree, out_mon.degree);
            fails++;
          end
          if (out_mon.last_result !== e.last_result) begin
            $error("last_result: expected %0b, got %0b", e.last_result, out_mon.last_result);
            fails++;
          end
          if (out_mon.status !== e.status) begin
            $error("status: expected %0b, got %0b", e.status, out_mon.status);
            fails++;
          end
        end
      end
    end
  end

endmodule

// File: verif/truncated_series_composition_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// truncated_series_composition_test
// drives series loads and centre settings, verdict from the checker's count
// ----------------------------------------------------------------------------
module truncated_series_composition_test;
  import tsc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic signed [COEF_W-1:0] cfg_data;
  int          fail_count;
  int          pending;

  // sender and receiver idle rates, in percent
  int          tx_idle_pct;
  int          rx_idle_pct;
  // long receiver hold-off, counted in its own process
  logic        rx_hold;
  int          items_sent;

  tsc_in_if  in_ch ();
  tsc_out_if out_ch ();

  truncated_series_composition i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  tsc_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous fixed limit on the whole run
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, or held off entirely
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // centre register write, only while the block is idle
  task automatic write_centre(input logic signed [COEF_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // one pair transaction; valid stays high across back-to-back pairs
  task automatic send_pair(input int outer_v, input int inner_v, input logic last_v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.outer_coef <= outer_v;
    in_ch.inner_coef <= inner_v;
    in_ch.last_pair  <= last_v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // coefficient value: mostly modest q16.16, sometimes any 32-bit pattern
  function automatic int pick_coef();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return int'($urandom_range(393216)) - 196608;
    endcase
  endfunction

  // whole load of n pairs, constant term on centre unless broken on purpose
  task automatic send_load(input int n, input int centre, input bit match);
    for (int k = 0; k < n; k++) begin
      send_pair(pick_coef(), (k == 0) ? (match ? centre : centre ^ (1 << $urandom_range(31)))
                                      : pick_coef(), k == n - 1);
    end
  endtask

  function automatic int pick_order();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 16 + $urandom_range(3);  // excess pairs dropped
    if (r < 8) return 16;
    return 1 + $urandom_range(5);
  endfunction

  task automatic random_loads(input int centre, input int item_goal);
    while (items_sent < item_goal) begin
      send_load(pick_order(), centre, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    int centres[4];
    in_ch.valid      <= 1'b0;
    in_ch.outer_coef <= '0;
    in_ch.inner_coef <= '0;
    in_ch.last_pair  <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    rx_hold          = 1'b0;
    tx_idle_pct      = 19;
    rx_idle_pct      = 64;
    items_sent       = 0;
    rst_n            = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: centre at reset value of zero
    send_pair(32'sh00010000, 0, 1'b1);                  // order zero
    send_pair(32'sh7fffffff, 0, 1'b0);                  // saturating extremes
    send_pair(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_pair(32'sh7fffffff, 32'sh80000000, 1'b1);
    send_pair(5, 32'sh00000001, 1'b1);                   // constant term mismatch
    send_pair(0, 32'shffffffff, 1'b0);
    send_pair(32'sh00020000, 32'sh00008000, 1'b1);       // mismatch on a longer load
    send_load(18, 0, 1'b1);                              // excess pairs beyond the store

    // sender pauses until every expected result has come
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);

    // long receiver hold-off while pairs keep coming, so the block backs up
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int n = 0; n < 4; n++) send_load(3, 0, 1'b1);

    centres = '{32'sh7fffffff, 32'sh80000000, int'($urandom()), 0};
    for (int p = 0; p < 4; p++) begin
      write_centre(centres[p]);
      // sender busy, receiver quiet at first; then swapped; then no idling
      if (p == 1) begin
        tx_idle_pct = 64;
        rx_idle_pct = 19;
      end else if (p >= 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_loads(centres[p], 60 + 40 * (p + 1));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
